>>> hdl/smts_pkg.sv
// Shared types, constants and helper functions of the midpoint triangle subdivider.
package smts_pkg;

  localparam int ATTR_W   = 32;  // width of one vertex attribute
  localparam int FRAC_DEF = 16;  // default number of fraction bits
  localparam int NORM_TOP = 30;  // largest normalized magnitude lies in [2^29, 2^30)
  localparam int QDEPTH   = 2;   // triangle queue depth

  typedef logic signed [ATTR_W-1:0] attr_t;
  typedef attr_t [2:0] vec3_t;

  typedef struct packed {
    attr_t pos_x;
    attr_t pos_y;
    attr_t pos_z;
    attr_t nrm_x;
    attr_t nrm_y;
    attr_t nrm_z;
    attr_t tan_x;
    attr_t tan_y;
    attr_t tan_z;
    attr_t tex_u;
    attr_t tex_v;
  } vtx_t;

  typedef struct packed {
    attr_t out_pos_x;
    attr_t out_pos_y;
    attr_t out_pos_z;
    attr_t out_nrm_x;
    attr_t out_nrm_y;
    attr_t out_nrm_z;
    attr_t out_tan_x;
    attr_t out_tan_y;
    attr_t out_tan_z;
    attr_t out_tex_u;
    attr_t out_tex_v;
    logic  group_last;
  } res_t;

  typedef struct packed {
    vtx_t v2;
    vtx_t v1;
    vtx_t v0;
  } tri_t;

  // Floored average of two signed values, computed without overflow.
  function automatic attr_t avg(attr_t a, attr_t b);
    logic [ATTR_W:0] s;
    s = {a[ATTR_W-1], a} + {b[ATTR_W-1], b};
    return s[ATTR_W:1];
  endfunction

  function automatic res_t mk_res(vtx_t v, logic last);
    res_t r;
    r.out_pos_x  = v.pos_x;
    r.out_pos_y  = v.pos_y;
    r.out_pos_z  = v.pos_z;
    r.out_nrm_x  = v.nrm_x;
    r.out_nrm_y  = v.nrm_y;
    r.out_nrm_z  = v.nrm_z;
    r.out_tan_x  = v.tan_x;
    r.out_tan_y  = v.tan_y;
    r.out_tan_z  = v.tan_z;
    r.out_tex_u  = v.tex_u;
    r.out_tex_v  = v.tex_v;
    r.group_last = last;
    return r;
  endfunction

endpackage

>>> hdl/midpoint_triangle_subdivider.sv
// Midpoint triangle subdivider: corners in, three corners and three midpoints out.
//
// Input channel: one vertex per transfer (push/full). Every third vertex closes a
// triangle, which the front end places in a two-entry triangle queue.
// Result channel: queue style (empty/pop); six vertices per triangle in the order
// v0, v1, v2, m01, m12, m02, with group_last set on the sixth.
// Corners leave first, one per cycle while the receiver keeps up. Each midpoint
// needs two passes through one iterative renormalizing unit (normal, then
// tangent); a pass is a shift search, a squaring of the three components, a
// square root and three divisions of 30 + FRAC_BITS + 1 quotient bits each.
// That unit sets the pace at which triangles leave.
// While the back end works, the front end keeps taking corners until the queue
// holds a waiting triangle and two more corners; full is high while two corners
// are held and the queue has no room, so only a third corner is ever refused.
// A stalled receiver holds the head result and stops the back end; once the
// queue fills behind it, the input stalls as well.
// Synchronous reset empties the queue, clears the corner count and drops any
// result in flight.
module midpoint_triangle_subdivider
  import smts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  vtx_t vertex,
  output logic empty,
  input  logic pop,
  output res_t result
);

  logic q_full;
  logic q_push;
  tri_t q_data;
  logic q_valid;
  logic q_pop;
  tri_t q_head;

  smts_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .vertex (vertex),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  smts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_data),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd      (q_pop),
    .rd_data (q_head)
  );

  smts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

>>> hdl/smts_front.sv
// Front end: collects the corners of a triangle and queues the complete triangle.
module smts_front
  import smts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  vtx_t vertex,
  input  logic q_full,
  output logic q_push,
  output tri_t q_data
);

  logic [1:0] corner_count;
  vtx_t       v0;
  vtx_t       v1;
  logic       take;

  // The third corner can only be taken when the queue has room for the triangle.
  assign full   = (corner_count == 2'd2) && q_full;
  assign take   = push && !full;
  assign q_push = take && (corner_count == 2'd2);
  assign q_data = '{v2: vertex, v1: v1, v0: v0};

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (take) begin
      if (corner_count == 2'd2) begin
        corner_count <= 2'd0;
      end else begin
        corner_count <= corner_count + 2'd1;
      end
      if (corner_count == 2'd0) begin
        v0 <= vertex;
      end
      if (corner_count == 2'd1) begin
        v1 <= vertex;
      end
    end
  end

endmodule

>>> hdl/smts_queue.sv
// Short queue of complete triangles between the front and back ends.
module smts_queue
  import smts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  tri_t wr_data,
  output logic q_full,
  output logic q_valid,
  input  logic rd,
  output tri_t rd_data
);

  localparam int QPW = $clog2(QDEPTH);

  tri_t           mem [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;

  assign q_full  = (count == (QPW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/smts_renorm.sv
// Iterative unit that renormalizes the sum of two vectors to unit length.
module smts_renorm
  import smts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  vec3_t a,
  input  vec3_t b,
  output logic  done,
  output vec3_t res
);

  localparam int MW  = (ATTR_W + 1 > NORM_TOP + 1) ? ATTR_W + 1 : NORM_TOP + 1;
  localparam int NW  = NORM_TOP + FRAC_BITS + 1;
  localparam int CW  = $clog2(NW + 1);
  localparam int LW  = 2 * NORM_TOP + 2;
  localparam int CMW = (NW > ATTR_W) ? NW : ATTR_W;
  localparam bit SAT_WIDE = (ATTR_W >= 64);
  localparam logic [ATTR_W-1:0] QMAX = {1'b0, {(ATTR_W-1){1'b1}}};

  typedef enum logic [7:0] {
    R_IDLE = 8'b00000001,
    R_NORM = 8'b00000010,
    R_SQ   = 8'b00000100,
    R_ROOT = 8'b00001000,
    R_DLD  = 8'b00010000,
    R_DIV  = 8'b00100000,
    R_STO  = 8'b01000000,
    R_DONE = 8'b10000000
  } rstate_t;

  rstate_t                   st;
  logic [2:0][MW-1:0]        mag;
  logic [2:0]                neg;
  logic [1:0]                ci;
  logic [2*NORM_TOP-1:0]     prod;
  logic [LW-1:0]             acc;
  logic [LW-1:0]             rn;
  logic [LW-1:0]             rt;
  logic [LW-1:0]             rbit;
  logic [NW-1:0]             num;
  logic [31:0]               rem;
  logic [CW-1:0]             dcnt;

  logic [2:0][ATTR_W:0]      ld_mag;
  logic [2:0]                ld_neg;
  logic                      any_hi;
  logic                      all_lo;
  logic [MW-1:0]             sel_m;
  logic [LW-1:0]             trial;
  logic [31:0]               rem_sh;
  logic [31:0]               dvs;
  logic                      qbit;
  logic [CMW-1:0]            q_ext;
  logic [ATTR_W-1:0]         qc;

  always_comb begin
    logic [ATTR_W:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s = {a[i][ATTR_W-1], a[i]} + {b[i][ATTR_W-1], b[i]};
      ld_neg[i] = s[ATTR_W];
      ld_mag[i] = s[ATTR_W] ? (~s + 1'b1) : s;
      // At 64 bits a magnitude of 2^64 saturates to all ones.
      if (SAT_WIDE && ld_mag[i][ATTR_W]) begin
        ld_mag[i] = {1'b0, {ATTR_W{1'b1}}};
      end
    end
  end

  assign any_hi = (mag[0][MW-1:NORM_TOP] != '0) || (mag[1][MW-1:NORM_TOP] != '0) ||
                  (mag[2][MW-1:NORM_TOP] != '0);
  assign all_lo = (mag[0][MW-1:NORM_TOP-1] == '0) && (mag[1][MW-1:NORM_TOP-1] == '0) &&
                  (mag[2][MW-1:NORM_TOP-1] == '0);

  always_comb begin
    unique case (ci)
      2'd0:    sel_m = mag[0];
      2'd1:    sel_m = mag[1];
      default: sel_m = mag[2];
    endcase
  end

  assign trial  = rt + rbit;
  assign dvs    = rt[31:0];
  assign rem_sh = {rem[30:0], num[NW-1]};
  assign qbit   = (rem_sh >= dvs);
  assign q_ext  = CMW'(num);
  assign qc     = (q_ext > CMW'(QMAX)) ? QMAX : q_ext[ATTR_W-1:0];
  assign done   = (st == R_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= R_IDLE;
    end else begin
      unique case (st)
        R_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= MW'(ld_mag[i]);
            end
            neg <= ld_neg;
            if (ld_mag == '0) begin
              res <= '0;
              st  <= R_DONE;
            end else begin
              st <= R_NORM;
            end
          end
        end
        R_NORM: begin
          // One bit of common shift per cycle until the largest lies in range.
          if (any_hi) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (all_lo) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            ci  <= 2'd0;
            acc <= '0;
            st  <= R_SQ;
          end
        end
        R_SQ: begin
          prod <= sel_m[NORM_TOP-1:0] * sel_m[NORM_TOP-1:0];
          if (ci != 2'd0) begin
            acc <= acc + LW'(prod);
          end
          if (ci == 2'd3) begin
            rn   <= acc + LW'(prod);
            rt   <= '0;
            rbit <= LW'(1) << (LW - 2);
            st   <= R_ROOT;
          end else begin
            ci <= ci + 2'd1;
          end
        end
        R_ROOT: begin
          if (rn >= trial) begin
            rn <= rn - trial;
            rt <= (rt >> 1) + rbit;
          end else begin
            rt <= rt >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            ci <= 2'd0;
            st <= R_DLD;
          end
        end
        R_DLD: begin
          num  <= (NW'(sel_m[NORM_TOP-1:0]) << FRAC_BITS) + NW'(rt[31:1]);
          rem  <= '0;
          dcnt <= CW'(NW);
          st   <= R_DIV;
        end
        R_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into num.
          rem  <= qbit ? (rem_sh - dvs) : rem_sh;
          num  <= {num[NW-2:0], qbit};
          dcnt <= dcnt - 1'b1;
          if (dcnt == CW'(1)) begin
            st <= R_STO;
          end
        end
        R_STO: begin
          res[ci] <= neg[ci] ? attr_t'(~qc + 1'b1) : attr_t'(qc);
          if (ci == 2'd2) begin
            st <= R_DONE;
          end else begin
            ci <= ci + 2'd1;
            st <= R_DLD;
          end
        end
        R_DONE: begin
          st <= R_IDLE;
        end
        default: begin
          st <= R_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/smts_back.sv
// Back end: emits the three corners and the three midpoints of each queued triangle.
module smts_back
  import smts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  tri_t job,
  output logic job_pop,
  output logic empty,
  input  logic pop,
  output res_t result
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_CORNER = 5'b00010,
    B_NRM    = 5'b00100,
    B_TAN    = 5'b01000,
    B_EMIT   = 5'b10000
  } bstate_t;

  bstate_t st;
  logic [1:0] idx;
  logic [1:0] k;
  logic       launched;
  logic       out_valid;
  vec3_t      nrm_r;
  vec3_t      tan_r;

  vtx_t  pa;
  vtx_t  pb;
  vtx_t  corner;
  vec3_t rn_a;
  vec3_t rn_b;
  logic  rn_start;
  logic  rn_done;
  vec3_t rn_res;
  logic  load_ok;
  logic  load_now;
  res_t  mid;

  always_comb begin
    unique case (k)
      2'd0: begin
        pa = job.v0;
        pb = job.v1;
      end
      2'd1: begin
        pa = job.v1;
        pb = job.v2;
      end
      default: begin
        pa = job.v0;
        pb = job.v2;
      end
    endcase
  end

  always_comb begin
    unique case (idx)
      2'd0:    corner = job.v0;
      2'd1:    corner = job.v1;
      default: corner = job.v2;
    endcase
  end

  assign rn_a = (st == B_TAN) ? {pa.tan_z, pa.tan_y, pa.tan_x} : {pa.nrm_z, pa.nrm_y, pa.nrm_x};
  assign rn_b = (st == B_TAN) ? {pb.tan_z, pb.tan_y, pb.tan_x} : {pb.nrm_z, pb.nrm_y, pb.nrm_x};
  assign rn_start = ((st == B_NRM) || (st == B_TAN)) && !launched;

  smts_renorm #(.FRAC_BITS(FRAC_BITS)) u_renorm (
    .clk   (clk),
    .rst   (rst),
    .start (rn_start),
    .a     (rn_a),
    .b     (rn_b),
    .done  (rn_done),
    .res   (rn_res)
  );

  always_comb begin
    mid.out_pos_x  = avg(pa.pos_x, pb.pos_x);
    mid.out_pos_y  = avg(pa.pos_y, pb.pos_y);
    mid.out_pos_z  = avg(pa.pos_z, pb.pos_z);
    mid.out_nrm_x  = nrm_r[0];
    mid.out_nrm_y  = nrm_r[1];
    mid.out_nrm_z  = nrm_r[2];
    mid.out_tan_x  = tan_r[0];
    mid.out_tan_y  = tan_r[1];
    mid.out_tan_z  = tan_r[2];
    mid.out_tex_u  = avg(pa.tex_u, pb.tex_u);
    mid.out_tex_v  = avg(pa.tex_v, pb.tex_v);
    mid.group_last = (k == 2'd2);
  end

  // The output register takes a new vertex when it is free or being drained.
  assign load_ok  = !out_valid || pop;
  assign load_now = load_ok && ((st == B_CORNER) || (st == B_EMIT));
  assign job_pop  = (st == B_EMIT) && load_ok && (k == 2'd2);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (load_now) begin
      result <= (st == B_CORNER) ? mk_res(corner, 1'b0) : mid;
    end
    if (rn_done && (st == B_NRM)) begin
      nrm_r <= rn_res;
    end
    if (rn_done && (st == B_TAN)) begin
      tan_r <= rn_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      idx       <= 2'd0;
      k         <= 2'd0;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_now) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (rn_start) begin
        launched <= 1'b1;
      end else if (rn_done) begin
        launched <= 1'b0;
      end
      unique case (st)
        B_IDLE: begin
          if (job_valid) begin
            idx <= 2'd0;
            st  <= B_CORNER;
          end
        end
        B_CORNER: begin
          if (load_ok) begin
            if (idx == 2'd2) begin
              k  <= 2'd0;
              st <= B_NRM;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        B_NRM: begin
          if (rn_done) begin
            st <= B_TAN;
          end
        end
        B_TAN: begin
          if (rn_done) begin
            st <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (load_ok) begin
            if (k == 2'd2) begin
              st <= B_IDLE;
            end else begin
              k  <= k + 2'd1;
              st <= B_NRM;
            end
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/smts_checker.sv
// Port-level checker for the midpoint triangle subdivider, with its bind.
module smts_checker
  import smts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input res_t result
);

  logic [1:0] in_cnt;
  logic [2:0] out_cnt;
  logic [2:0] pending;
  logic       in_xfer;
  logic       out_xfer;
  logic       tri_done;
  logic       grp_done;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;
  assign tri_done = in_xfer && (in_cnt == 2'd2);
  assign grp_done = out_xfer && result.group_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= 2'd0;
      out_cnt <= 3'd0;
      pending <= 3'd0;
    end else begin
      if (in_xfer) begin
        in_cnt <= (in_cnt == 2'd2) ? 2'd0 : in_cnt + 2'd1;
      end
      if (out_xfer) begin
        out_cnt <= (out_cnt == 3'd5) ? 3'd0 : out_cnt + 3'd1;
      end
      if (tri_done && !grp_done) begin
        pending <= pending + 3'd1;
      end else if (grp_done && !tri_done) begin
        pending <= pending - 3'd1;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result channel not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed or vanished");

  a_group_pos: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (result.group_last == (out_cnt == 3'd5)))
    else $error("group_last not on every sixth transfer");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 3'd0))
    else $error("result shown without a completed triangle");

endmodule

bind midpoint_triangle_subdivider smts_checker u_smts_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

>>> tb/tb.sv
// Testbench for the midpoint triangle subdivider: random vertex traffic against a predictor.
`timescale 1ns / 100ps

module tb;
  import smts_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;
  localparam int NRAND      = 468;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  vtx_t vertex = '0;
  res_t result;

  midpoint_triangle_subdivider dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .empty(empty), .pop(pop), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vtx_t pend_q[$];
  bit   drain_q[$];   // set: hold this vertex until every expected result is out
  res_t expect_q[$];
  int   errors = 0;
  int   results_seen = 0;

  // Model state: corners held for the open triangle.
  vtx_t corner0, corner1;
  int   corners_held = 0;

  function automatic attr_t attr_of(vtx_t v, int k);
    return v[ATTR_W*(10-k) +: ATTR_W];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic attr_t floor_avg(attr_t a, attr_t b);
    logic signed [ATTR_W:0] s;
    s = a + b;
    s = s >>> 1;
    return s[ATTR_W-1:0];
  endfunction

  // Direction of (a + b) on components base..base+2, rescaled to unit length.
  function automatic vtx_t unit_mid(vtx_t a, vtx_t b, vtx_t o, int base);
    logic [63:0] mag[3];
    logic [63:0] mx, my, maxm, len2, r, q;
    logic signed [63:0] x, y;
    bit neg[3];
    int blen;
    maxm = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      x = attr_of(a, base + i);
      y = attr_of(b, base + i);
      mx = x[63] ? -x : x;
      my = y[63] ? -y : y;
      if (x[63] == y[63]) begin
        mag[i] = mx + my;
        neg[i] = x[63];
      end else if (mx >= my) begin
        mag[i] = mx - my;
        neg[i] = x[63];
      end else begin
        mag[i] = my - mx;
        neg[i] = y[63];
      end
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) begin
      for (int i = 0; i < 3; i++) o[ATTR_W*(10-base-i) +: ATTR_W] = '0;
      return o;
    end
    blen = 0;
    while (blen < 64 && (maxm >> blen) != 0) blen++;
    for (int i = 0; i < 3; i++) begin
      if (blen > NORM_TOP) mag[i] = mag[i] >> (blen - NORM_TOP);
      else mag[i] = mag[i] << (NORM_TOP - blen);
      len2 = len2 + mag[i] * mag[i];
    end
    r = root64(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC_DEF) + (r >> 1)) / r;
      if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
      if (neg[i]) q = -q;
      o[ATTR_W*(10-base-i) +: ATTR_W] = q[ATTR_W-1:0];
    end
    return o;
  endfunction

  function automatic vtx_t midpoint_of(vtx_t a, vtx_t b);
    vtx_t m;
    m = '0;
    for (int k = 0; k < 11; k++)
      m[ATTR_W*(10-k) +: ATTR_W] = floor_avg(attr_of(a, k), attr_of(b, k));
    m = unit_mid(a, b, m, 3);
    m = unit_mid(a, b, m, 6);
    return m;
  endfunction

  function automatic res_t as_result(vtx_t v, logic last);
    res_t r;
    r = {v, last};
    return r;
  endfunction

  task automatic queue_result(res_t r);
    expect_q.insert(expect_q.size(), r);
  endtask

  task automatic take_corner(vtx_t v);
    if (corners_held == 0) begin
      corner0 = v;
      corners_held = 1;
    end else if (corners_held == 1) begin
      corner1 = v;
      corners_held = 2;
    end else begin
      corners_held = 0;
      queue_result(as_result(corner0, 1'b0));
      queue_result(as_result(corner1, 1'b0));
      queue_result(as_result(v, 1'b0));
      queue_result(as_result(midpoint_of(corner0, corner1), 1'b0));
      queue_result(as_result(midpoint_of(corner1, v), 1'b0));
      queue_result(as_result(midpoint_of(corner0, v), 1'b1));
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_corner(vertex);
        void'(pend_q.pop_front());
        void'(drain_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 18);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
        end
      end
      go = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pend_q.size() != 0 && !(drain_q[0] && expect_q.size() != 0)) go = 1'b1;
      push <= go;
      if (go) vertex <= pend_q[0];
    end
  end

  // Receiver: stall pattern changes by phase, plus one long hold-off.
  int cyc = 0;
  int hold_left = 0;
  bit long_done = 0;
  always @(posedge clk) begin
    res_t want;
    int ph;
    cyc++;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expect_q.size() == 0) begin
          report("unexpected transfer", result.out_pos_x, '0);
        end else begin
          want = expect_q.pop_front();
          for (int k = 0; k < 11; k++)
            if (result[1 + ATTR_W*(10-k) +: ATTR_W] !== want[1 + ATTR_W*(10-k) +: ATTR_W])
              report($sformatf("field %0d", k), result[1 + ATTR_W*(10-k) +: ATTR_W],
                     want[1 + ATTR_W*(10-k) +: ATTR_W]);
          if (result.group_last !== want.group_last)
            report("group_last", result.group_last, want.group_last);
        end
        results_seen++;
        if (results_seen == 60 && !long_done) begin
          long_done = 1;
          hold_left = LONG_HOLD;
        end
      end
      ph = (cyc / 4000) % 3;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (ph == 0) begin
        pop <= 1'b1;
      end else if (ph == 1) begin
        pop <= ($urandom_range(0, 3) != 0);
      end else begin
        pop <= ($urandom_range(0, 7) == 0);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL midpoint_triangle_subdivider");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic attr_t pick_attr();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $signed($urandom_range(0, 64)) - 32;
      2: return $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vtx_t rand_vertex();
    vtx_t v;
    for (int k = 0; k < 11; k++) v[ATTR_W*(10-k) +: ATTR_W] = pick_attr();
    return v;
  endfunction

  task automatic add(vtx_t v, bit drain);
    pend_q.insert(pend_q.size(), v);
    drain_q.insert(drain_q.size(), drain);
  endtask

  initial begin
    vtx_t v, w;
    // Most-positive extremes, most-negative values and a zero.
    add({11{32'sh7fff_ffff}}, 0);
    add({11{32'sh7fff_ffff}}, 0);
    add({11{32'sh8000_0000}}, 0);
    add({11{32'sh8000_0000}}, 0);
    add({11{32'sh8000_0000}}, 0);
    add('0, 0);
    // Opposite vectors: normal and tangent sums cancel to zero.
    v = rand_vertex();
    w = v;
    for (int k = 3; k < 9; k++) w[ATTR_W*(10-k) +: ATTR_W] = -attr_of(v, k);
    add(v, 0);
    add(w, 0);
    add(v, 0);
    // Tiny and unit-sized vectors.
    add({11{32'sh0000_0001}}, 0);
    add({11{32'shffff_ffff}}, 0);
    add({11{32'sh0001_0000}}, 0);
    for (int n = 0; n < NRAND; n++) add(rand_vertex(), n == NRAND / 2);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (pend_q.size() != 0 || expect_q.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS midpoint_triangle_subdivider");
    else $display("FAIL midpoint_triangle_subdivider");
    $finish;
  end

endmodule
